// ===== rtl/radix_digit_emitter_core_assert.svh =====
// Assertion macros for the radix digit emitter.
`ifndef RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH
`define RADIX_DIGIT_EMITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define RDE_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rde: same-cycle check failed");
`define RDE_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rde: next-cycle check failed");
`else
`define RDE_AST_IMP(lbl, ante, cons)
`define RDE_AST_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/rde_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function.
`default_nettype none

package rde_pkg;

  localparam int BASE_W  = 5;
  localparam int DIGIT_W = 4;
  localparam int CHAR_W  = 7;

  localparam logic [BASE_W-1:0] BASE_MIN = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_0 = 7'h30;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_A = 7'h41;  // 'A'

  // Divider status toward the sequencer
  typedef struct packed {
    logic               done;    // one digit finished this cycle
    logic               q_zero;  // quotient after this digit is zero
    logic [DIGIT_W-1:0] rem;     // the digit
  } div_status_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_0 + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rde_digit_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, repeats until zero.
`default_nettype none

module rde_digit_div #(
  parameter int VALUE_BITS = 31
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [VALUE_BITS-1:0]      value,
  input  wire logic [rde_pkg::BASE_W-1:0] base,
  output rde_pkg::div_status_t            status
);

  localparam int BCW = $clog2(VALUE_BITS);

  logic                        busy_r;
  logic                        busy_nxt;
  logic [VALUE_BITS-1:0]       q_r;
  logic [VALUE_BITS-1:0]       q_nxt;
  logic [rde_pkg::DIGIT_W-1:0] rem_r;
  logic [rde_pkg::DIGIT_W-1:0] rem_nxt;
  logic [rde_pkg::BASE_W-1:0]  base_r;
  logic [BCW-1:0]              cnt_r;
  logic [BCW-1:0]              cnt_nxt;
  logic [rde_pkg::BASE_W-1:0]  trial;
  logic [rde_pkg::BASE_W-1:0]  diff;
  logic                        ge;
  logic [VALUE_BITS-1:0]       q_step;
  logic [rde_pkg::DIGIT_W-1:0] rem_step;
  logic                        last_bit;

  // shift in the next dividend bit, subtract if it fits
  assign trial    = {rem_r, q_r[VALUE_BITS-1]};
  assign ge       = (trial >= base_r);
  assign diff     = trial - base_r;
  assign rem_step = ge ? diff[rde_pkg::DIGIT_W-1:0] : trial[rde_pkg::DIGIT_W-1:0];
  assign q_step   = {q_r[VALUE_BITS-2:0], ge};
  assign last_bit = (cnt_r == BCW'(VALUE_BITS - 1));

  always_comb begin
    busy_nxt = busy_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      q_nxt    = value;
      rem_nxt  = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      q_nxt = q_step;
      if (last_bit) begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (q_step == '0) begin
          busy_nxt = 1'b0;
        end
      end else begin
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      base_r <= base;
    end
  end

  assign status.done   = busy_r && last_bit && !start;
  assign status.q_zero = (q_step == '0);
  assign status.rem    = rem_step;

endmodule

`default_nettype wire

// ===== rtl/radix_digit_emitter_core.sv =====
// Radix digit emitter top level: integer to ASCII digits in base 2..16, MSD first.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+----------------------------------------
//  in_     | input     | in_valid / in_ready   | in_value, in_base
//  out_    | output    | out_valid / out_ready | out_digit_char, out_last, out_bad_base
//
// Flow: one word in at a time; each digit takes one full bit-serial divider pass,
//   then each digit is popped through a registered stack read and then an output
//   load. A zero value or a bad base gives a single output word.
// Reset: synchronous, active low; clears control only, the stack is never cleared.
// Stalls: out_ready low holds the output register and the pop sequence;
//   the divider never stalls.
`default_nettype none
`include "radix_digit_emitter_core_assert.svh"

module radix_digit_emitter_core #(
  parameter int VALUE_BITS  = 31,
  parameter int STACK_DEPTH = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0]      in_value,
  input  wire logic [rde_pkg::BASE_W-1:0] in_base,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic [rde_pkg::CHAR_W-1:0] out_digit_char,
  output      logic                       out_last,
  output      logic                       out_bad_base
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_DIV  = 3'd1;  // divider producing digits, LSD first
  localparam logic [2:0] S_RD   = 3'd2;  // read top of stack
  localparam logic [2:0] S_LD   = 3'd3;  // move popped digit to output reg
  localparam logic [2:0] S_ONE  = 3'd4;  // single word: zero value or bad base

  logic [2:0]                  st_r;
  logic [2:0]                  st_nxt;
  logic [CW-1:0]               dcnt_r;
  logic [CW-1:0]               dcnt_nxt;
  logic [CW-1:0]               dcnt_m1;
  logic [rde_pkg::CHAR_W-1:0]  one_char_r;
  logic [rde_pkg::CHAR_W-1:0]  one_char_nxt;
  logic                        one_bad_r;
  logic                        one_bad_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [rde_pkg::CHAR_W-1:0]  out_char_r;
  logic [rde_pkg::CHAR_W-1:0]  out_char_nxt;
  logic                        out_last_r;
  logic                        out_last_nxt;
  logic                        out_bad_r;
  logic                        out_bad_nxt;
  logic                        out_load;
  logic                        out_free;
  logic                        in_bad;
  logic                        in_zero;
  logic                        div_start;
  logic                        mem_we;
  rde_pkg::div_status_t        div_st;

  // digit stack
  logic [rde_pkg::DIGIT_W-1:0] stack_mem [STACK_DEPTH];
  logic [rde_pkg::DIGIT_W-1:0] rd_data_r;

  rde_digit_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .value (in_value),
    .base  (in_base),
    .status(div_st)
  );

  assign in_ready = (st_r == S_IDLE);
  assign in_bad   = (in_base < rde_pkg::BASE_MIN) || (in_base > rde_pkg::BASE_MAX);
  assign in_zero  = (in_value == '0);
  assign out_free = !out_valid_r || out_ready;
  assign dcnt_m1  = dcnt_r - 1'b1;

  always_comb begin
    st_nxt       = st_r;
    dcnt_nxt     = dcnt_r;
    one_char_nxt = one_char_r;
    one_bad_nxt  = one_bad_r;
    out_load     = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    div_start    = 1'b0;
    mem_we       = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_bad || in_zero) begin
            one_char_nxt = in_bad ? '0 : rde_pkg::CHAR_0;
            one_bad_nxt  = in_bad;
            st_nxt       = S_ONE;
          end else begin
            div_start = 1'b1;
            dcnt_nxt  = '0;
            st_nxt    = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          // digits past a full stack are dropped
          if (dcnt_r < CW'(STACK_DEPTH)) begin
            mem_we   = 1'b1;
            dcnt_nxt = dcnt_r + 1'b1;
          end
          if (div_st.q_zero) begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        dcnt_nxt = dcnt_m1;
        st_nxt   = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_nxt = rde_pkg::glyph(rd_data_r);
          out_last_nxt = (dcnt_r == '0);
          out_bad_nxt  = 1'b0;
          st_nxt       = (dcnt_r == '0) ? S_IDLE : S_RD;
        end
      end
      S_ONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_char_nxt = one_char_r;
          out_last_nxt = 1'b1;
          out_bad_nxt  = one_bad_r;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = out_load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    one_char_r <= one_char_nxt;
    one_bad_r  <= one_bad_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  // stack write: push remainder
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[dcnt_r[AW-1:0]] <= div_st.rem;
    end
  end

  // stack read: registered pop
  always_ff @(posedge clk) begin
    if (st_r == S_RD) begin
      rd_data_r <= stack_mem[dcnt_m1[AW-1:0]];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign out_bad_base   = out_bad_r;

  `RDE_AST_NXT(a_accept_leaves_idle, in_valid && in_ready, st_r != S_IDLE)
  `RDE_AST_IMP(a_bad_is_single, out_valid_r && out_bad_r, out_last_r && (out_char_r == '0))
  `RDE_AST_IMP(a_div_done_in_div, div_st.done, st_r == S_DIV)
  `RDE_AST_IMP(a_pop_nonempty, st_r == S_RD, dcnt_r != '0)
  `RDE_AST_IMP(a_count_bound, st_r == S_DIV, dcnt_r <= CW'(STACK_DEPTH))

endmodule

`default_nettype wire
